// ===== rtl/core/obb_pkg.sv =====
// Shared types and helpers for the oriented box to bounding box core.
// Used by obb_rotmat and oriented_box_to_aabb_core; depends on nothing else.

package obb_pkg;

	// Rotation matrix entries are rounded to this many fraction bits.
	localparam int unsigned MAT_FRAC = 14;
	// Unrounded matrix entries are Q.28 and fit in this many signed bits.
	localparam int unsigned FULL_W   = 35;
	// A rounded entry lies within +-2^18.
	localparam int unsigned RM_W     = 20;

	typedef logic signed [RM_W-1:0]   rm_elem_t;
	typedef logic signed [FULL_W-1:0] full_elem_t;

	// Load strobes for the two register stages of the matrix unit.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} rm_ctrl_t;

	// Round a Q.28 entry to Q.14: add half, then floor.
	function automatic rm_elem_t round_mat(input full_elem_t v);
		full_elem_t t;
		t = (v + (full_elem_t'(1) <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
		return t[RM_W-1:0];
	endfunction

	// Clamp a 64-bit signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic same;
		same = (&v[63:31]) || !(|v[63:31]);
		if (same) begin
			return v[31:0];
		end else if (v[63]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7FFF_FFFF;
		end
	endfunction

endpackage

// ===== rtl/core/obb_rotmat.sv =====
// Two-stage unit that turns a Q1.14 quaternion into a rotation matrix in Q.14.
// Depends on obb_pkg for the entry types, the load strobes and the rounding helper.

module obb_rotmat import obb_pkg::*; (
	input  logic               clk,
	input  rm_ctrl_t           ctrl,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output rm_elem_t           rm_s2 [3][3]
);

	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [31:0] wx_s1, wy_s1, wz_s1;
	full_elem_t         full [3][3];
	full_elem_t         one;

	// Stage 1: the nine component products, one multiplier each.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
			wy_s1 <= quat_w * quat_y;
			wz_s1 <= quat_w * quat_z;
		end
	end

	// Stage 2: combine the products into the Q.28 matrix.
	always_comb begin
		one        = full_elem_t'(1) <<< 28;
		full[0][0] = one - ((full_elem_t'(yy_s1) + full_elem_t'(zz_s1)) <<< 1);
		full[0][1] = (full_elem_t'(xy_s1) - full_elem_t'(wz_s1)) <<< 1;
		full[0][2] = (full_elem_t'(xz_s1) + full_elem_t'(wy_s1)) <<< 1;
		full[1][0] = (full_elem_t'(xy_s1) + full_elem_t'(wz_s1)) <<< 1;
		full[1][1] = one - ((full_elem_t'(xx_s1) + full_elem_t'(zz_s1)) <<< 1);
		full[1][2] = (full_elem_t'(yz_s1) - full_elem_t'(wx_s1)) <<< 1;
		full[2][0] = (full_elem_t'(xz_s1) - full_elem_t'(wy_s1)) <<< 1;
		full[2][1] = (full_elem_t'(yz_s1) + full_elem_t'(wx_s1)) <<< 1;
		full[2][2] = one - ((full_elem_t'(xx_s1) + full_elem_t'(yy_s1)) <<< 1);
	end

	// Each entry is rounded to Q.14 as it is registered.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rm_s2[i][j] <= round_mat(full[i][j]);
				end
			end
		end
	end

endmodule

// ===== rtl/core/oriented_box_to_aabb_core.sv =====
// Top level of the oriented box to axis-aligned bounding box core.
// Depends on obb_pkg and instantiates obb_rotmat for the rotation matrix.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid, in_stall | pos_x/y/z, scale_x/y/z, quat_w/x/y/z
//  out     | output    | out_valid, out_stall | min_x/y/z, max_x/y/z
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// Five register stages: products, matrix rounding and scaling, matrix products,
// row sums, and the saturated corners in the output register. One item is accepted
// in every cycle while in_stall is low. A stall on the output propagates back
// stage by stage; empty stages still fill, so in_stall rises only when all five
// stages hold items. Reset clears the valid bits and returns the configuration
// to a unit box with no offset.

module oriented_box_to_aabb_core import obb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	// Input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        scale_x,
	input  logic [30:0]        scale_y,
	input  logic [30:0]        scale_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	// Output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] min_x,
	output logic signed [31:0] min_y,
	output logic signed [31:0] min_z,
	output logic signed [31:0] max_x,
	output logic signed [31:0] max_y,
	output logic signed [31:0] max_z
);

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_BOX_SIZE_X   = 3'd0;
	localparam logic [2:0] REG_BOX_SIZE_Y   = 3'd1;
	localparam logic [2:0] REG_BOX_SIZE_Z   = 3'd2;
	localparam logic [2:0] REG_CENTER_OFF_X = 3'd3;
	localparam logic [2:0] REG_CENTER_OFF_Y = 3'd4;
	localparam logic [2:0] REG_CENTER_OFF_Z = 3'd5;

	localparam logic [30:0] BOX_SIZE_RESET = 31'd65536;

	// Configuration registers
	logic [30:0]        box_size_q   [3];
	logic signed [31:0] center_off_q [3];

	// Pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	rm_ctrl_t rm_ctrl;

	// Stage data
	logic signed [31:0] pos_in    [3];
	logic [30:0]        scale_in  [3];
	logic [61:0]        hp_d      [3];
	logic signed [62:0] sp_d      [3];
	logic [61:0]        hp_s1     [3];
	logic signed [62:0] sp_s1     [3];
	logic signed [31:0] pos_s1    [3];

	logic [61:0]        hsh       [3];
	logic signed [62:0] ssh       [3];
	logic [30:0]        half_d    [3];
	logic signed [31:0] scaled_d  [3];
	logic [30:0]        half_s2   [3];
	logic signed [31:0] scaled_s2 [3];
	logic signed [31:0] pos_s2    [3];
	rm_elem_t           rm_s2     [3][3];

	logic [RM_W-2:0]    rm_abs    [3][3];
	logic signed [51:0] rp_s3     [3][3];
	logic [49:0]        ep_s3     [3][3];
	logic signed [31:0] pos_s3    [3];

	logic signed [53:0] racc      [3];
	logic signed [53:0] rrnd      [3];
	logic [51:0]        eacc      [3];
	logic [51:0]        ernd      [3];
	logic signed [39:0] rot_s4    [3];
	logic [37:0]        ext_s4    [3];
	logic signed [31:0] pos_s4    [3];

	logic signed [40:0] center    [3];
	logic signed [41:0] lo        [3];
	logic signed [41:0] hi        [3];
	logic signed [31:0] min_s5    [3];
	logic signed [31:0] max_s5    [3];

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				box_size_q[j]   <= BOX_SIZE_RESET;
				center_off_q[j] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_SIZE_X:   box_size_q[0]   <= cfg_wdata[30:0];
				REG_BOX_SIZE_Y:   box_size_q[1]   <= cfg_wdata[30:0];
				REG_BOX_SIZE_Z:   box_size_q[2]   <= cfg_wdata[30:0];
				REG_CENTER_OFF_X: center_off_q[0] <= cfg_wdata;
				REG_CENTER_OFF_Y: center_off_q[1] <= cfg_wdata;
				REG_CENTER_OFF_Z: center_off_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Each stage moves on when it is empty or the stage after it moves.
	assign en_s5    = !v_s5 || !out_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	assign rm_ctrl = '{ld_s1: en_s1 && in_valid, ld_s2: en_s2 && v_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Rotation matrix, ready alongside stage 2.
	obb_rotmat u_rotmat (
		.clk    (clk),
		.ctrl   (rm_ctrl),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.rm_s2  (rm_s2)
	);

	// Stage 1: size times scale and offset times scale.
	always_comb begin
		pos_in[0]   = pos_x;
		pos_in[1]   = pos_y;
		pos_in[2]   = pos_z;
		scale_in[0] = scale_x;
		scale_in[1] = scale_y;
		scale_in[2] = scale_z;
		for (int j = 0; j < 3; j++) begin
			hp_d[j] = box_size_q[j] * scale_in[j];
			sp_d[j] = center_off_q[j] * $signed({1'b0, scale_in[j]});
		end
	end

	always_ff @(posedge clk) begin
		if (rm_ctrl.ld_s1) begin
			hp_s1  <= hp_d;
			sp_s1  <= sp_d;
			pos_s1 <= pos_in;
		end
	end

	// Stage 2: half extents and scaled offset, both shifted down and clamped.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			hsh[j]      = hp_s1[j] >> (FRAC_BITS + 1);
			half_d[j]   = (|hsh[j][61:31]) ? '1 : hsh[j][30:0];
			ssh[j]      = sp_s1[j] >>> FRAC_BITS;
			scaled_d[j] = sat32(64'(ssh[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (rm_ctrl.ld_s2) begin
			half_s2   <= half_d;
			scaled_s2 <= scaled_d;
			pos_s2    <= pos_s1;
		end
	end

	// Stage 3: matrix entries times the offset and, in magnitude, the half extents.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rm_abs[i][j] = rm_s2[i][j][RM_W-1] ? (RM_W-1)'(-rm_s2[i][j])
				                                   : rm_s2[i][j][RM_W-2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rp_s3[i][j] <= rm_s2[i][j] * scaled_s2[j];
					ep_s3[i][j] <= rm_abs[i][j] * half_s2[j];
				end
			end
			pos_s3 <= pos_s2;
		end
	end

	// Stage 4: row sums, rounded from Q.14.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			racc[i] = 54'(rp_s3[i][0]) + 54'(rp_s3[i][1]) + 54'(rp_s3[i][2]);
			rrnd[i] = (racc[i] + (54'sd1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
			eacc[i] = 52'(ep_s3[i][0]) + 52'(ep_s3[i][1]) + 52'(ep_s3[i][2]);
			ernd[i] = (eacc[i] + (52'd1 << (MAT_FRAC - 1))) >> MAT_FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				rot_s4[i] <= rrnd[i][39:0];
				ext_s4[i] <= ernd[i][37:0];
			end
			pos_s4 <= pos_s3;
		end
	end

	// Stage 5: world centre, then the two corners clamped into the output register.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			center[i] = 41'(pos_s4[i]) + 41'(rot_s4[i]);
			lo[i]     = 42'(center[i]) - 42'($signed({1'b0, ext_s4[i]}));
			hi[i]     = 42'(center[i]) + 42'($signed({1'b0, ext_s4[i]}));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			for (int i = 0; i < 3; i++) begin
				min_s5[i] <= sat32(64'(lo[i]));
				max_s5[i] <= sat32(64'(hi[i]));
			end
		end
	end

	assign out_valid = v_s5;
	assign min_x     = min_s5[0];
	assign min_y     = min_s5[1];
	assign min_z     = min_s5[2];
	assign max_x     = max_s5[0];
	assign max_y     = max_s5[1];
	assign max_z     = max_s5[2];

endmodule

// ===== tb/obb_bounds_checker.sv =====
// Bounds checker for the oriented box to bounding box core: keeps its own copy of the
// box registers, predicts the corners of every accepted item and compares the results.
// Stand-alone; it only watches the ports of the core.

module obb_bounds_checker #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        scale_x,
	input  logic [30:0]        scale_y,
	input  logic [30:0]        scale_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] min_x,
	input  logic signed [31:0] min_y,
	input  logic signed [31:0] min_z,
	input  logic signed [31:0] max_x,
	input  logic signed [31:0] max_y,
	input  logic signed [31:0] max_z,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// The first three registers hold the box size, the next three the centre offset.
	localparam int unsigned NUM_SIZE_REGS = 3;
	localparam int unsigned NUM_REGS      = 6;
	localparam int unsigned MAT_SHIFT     = 14;
	localparam longint      MAT_HALF      = longint'(1) << (MAT_SHIFT - 1);
	localparam longint      S32_MAX       = 64'sd2147483647;
	localparam longint      S32_MIN       = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] lo_z;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
		logic signed [31:0] hi_z;
	} bounds_t;

	logic [30:0]        box_size [NUM_SIZE_REGS];
	logic signed [31:0] centre_off [NUM_SIZE_REGS];
	bounds_t            bounds_q [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// Clamp to the 32-bit signed range.
	function automatic longint clip32(input longint v);
		if (v > S32_MAX) begin
			return S32_MAX;
		end else if (v < S32_MIN) begin
			return S32_MIN;
		end
		return v;
	endfunction

	// Round away the lower fraction bits: add half, then floor.
	function automatic longint round_mat(input longint v);
		return (v + MAT_HALF) >>> MAT_SHIFT;
	endfunction

	// Corners of the item currently on the input ports, under the current registers.
	function automatic bounds_t predict_bounds();
		longint  qw, qx, qy, qz, one;
		longint  full [3][3];
		longint  rot [3][3];
		longint  pos [3];
		longint  half [3];
		longint  scaled [3];
		longint  lo [3];
		longint  hi [3];
		logic [30:0] sc [3];
		logic [63:0] hprod;
		longint  racc, eacc, centre, ext, mag;
		bounds_t b;
		qw = longint'(quat_w);
		qx = longint'(quat_x);
		qy = longint'(quat_y);
		qz = longint'(quat_z);
		one = longint'(1) << 28;
		// Rotation matrix in Q.28, rounded to Q.14; the quaternion is not normalised.
		full[0][0] = one - 2 * (qy * qy + qz * qz);
		full[0][1] = 2 * (qx * qy - qw * qz);
		full[0][2] = 2 * (qx * qz + qw * qy);
		full[1][0] = 2 * (qx * qy + qw * qz);
		full[1][1] = one - 2 * (qx * qx + qz * qz);
		full[1][2] = 2 * (qy * qz - qw * qx);
		full[2][0] = 2 * (qx * qz - qw * qy);
		full[2][1] = 2 * (qy * qz + qw * qx);
		full[2][2] = one - 2 * (qx * qx + qy * qy);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot[i][j] = round_mat(full[i][j]);
			end
		end
		pos[0] = longint'(pos_x);
		pos[1] = longint'(pos_y);
		pos[2] = longint'(pos_z);
		sc[0] = scale_x;
		sc[1] = scale_y;
		sc[2] = scale_z;
		// Half extents and the scaled centre offset, each per local axis.
		for (int j = 0; j < 3; j++) begin
			hprod = 64'(box_size[j]) * 64'(sc[j]);
			hprod = hprod >> (FRAC_BITS + 1);
			half[j] = (hprod > 64'(S32_MAX)) ? S32_MAX : longint'(hprod);
			scaled[j] = clip32((longint'(centre_off[j]) * longint'(sc[j])) >>> FRAC_BITS);
		end
		// Rotated centre plus position, and the extent from the absolute matrix.
		for (int i = 0; i < 3; i++) begin
			racc = 0;
			eacc = 0;
			for (int j = 0; j < 3; j++) begin
				mag = (rot[i][j] < 0) ? -rot[i][j] : rot[i][j];
				racc += rot[i][j] * scaled[j];
				eacc += mag * half[j];
			end
			centre = pos[i] + round_mat(racc);
			ext = round_mat(eacc);
			lo[i] = clip32(centre - ext);
			hi[i] = clip32(centre + ext);
		end
		b.lo_x = lo[0][31:0];
		b.lo_y = lo[1][31:0];
		b.lo_z = lo[2][31:0];
		b.hi_x = hi[0][31:0];
		b.hi_y = hi[1][31:0];
		b.hi_z = hi[2][31:0];
		return b;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Register writes, result checks and predictions, all on the rising edge.
	always @(posedge clk or negedge arst_n) begin
		bounds_t want;
		if (!arst_n) begin
			for (int j = 0; j < NUM_SIZE_REGS; j++) begin
				box_size[j]   = 31'(1) << FRAC_BITS;
				centre_off[j] = '0;
			end
			bounds_q.delete();
		end else begin
			// Indexes past the last register are ignored.
			if (cfg_we === 1'b1) begin
				if (cfg_index < NUM_SIZE_REGS) begin
					box_size[cfg_index] = cfg_wdata[30:0];
				end else if (cfg_index < NUM_REGS) begin
					centre_off[cfg_index - NUM_SIZE_REGS] = cfg_wdata;
				end
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (bounds_q.size() == 0) begin
					$error("result item arrived with no item outstanding");
					errors++;
				end else begin
					want = bounds_q.pop_front();
					check_field("min_x", want.lo_x, min_x);
					check_field("min_y", want.lo_y, min_y);
					check_field("min_z", want.lo_z, min_z);
					check_field("max_x", want.hi_x, max_x);
					check_field("max_y", want.hi_y, max_y);
					check_field("max_z", want.hi_z, max_z);
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				bounds_q.push_back(predict_bounds());
			end
		end
		pending = bounds_q.size();
	end

endmodule

// ===== tb/tb_oriented_box_to_aabb_core.sv =====
// Testbench top for oriented_box_to_aabb_core: drives directed and random items and
// register settings, idles both channels at random and reports the verdict.
// Depends on the core and on obb_bounds_checker, which does all the checking.

module tb_oriented_box_to_aabb_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAC_BITS    = 16;
	localparam int          NUM_DIRECTED = 12;
	localparam int          NUM_PHASES   = 10;
	localparam int          PHASE_ITEMS  = 50;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          UNIT         = 65536;
	localparam int          Q_ONE        = 16384;

	typedef enum logic [2:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_OFF_X,
		REG_OFF_Y,
		REG_OFF_Z,
		REG_SPARE_A,
		REG_SPARE_B
	} reg_index_e;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [30:0]        sx;
		logic [30:0]        sy;
		logic [30:0]        sz;
		logic signed [15:0] qw;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
	} pose_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_wdata = '0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] pos_x     = '0;
	logic signed [31:0] pos_y     = '0;
	logic signed [31:0] pos_z     = '0;
	logic [30:0]        scale_x   = '0;
	logic [30:0]        scale_y   = '0;
	logic [30:0]        scale_z   = '0;
	logic signed [15:0] quat_w    = '0;
	logic signed [15:0] quat_x    = '0;
	logic signed [15:0] quat_y    = '0;
	logic signed [15:0] quat_z    = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] min_x, min_y, min_z, max_x, max_y, max_z;
	int                 errors;
	int                 pending;
	logic               in_taken  = 1'b0;
	logic               out_taken = 1'b0;
	bit                 calm      = 1'b0;

	always #1 clk = ~clk;

	oriented_box_to_aabb_core #(.FRAC_BITS(FRAC_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_x(min_x), .min_y(min_y), .min_z(min_z),
		.max_x(max_x), .max_y(max_y), .max_z(max_z)
	);

	obb_bounds_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_x(min_x), .min_y(min_y), .min_z(min_z),
		.max_x(max_x), .max_y(max_y), .max_z(max_z),
		.errors(errors), .pending(pending)
	);

	// Handshakes are sampled on the rising edge and read by the drivers at the falling edge.
	always @(posedge clk) begin
		in_taken  <= (in_valid && !in_stall) === 1'b1;
		out_taken <= (out_valid && !out_stall) === 1'b1;
	end

	// Result side: stall for a random number of cycles before each result item.
	initial begin
		int hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 4);
			repeat (hold) begin
				out_stall <= 1'b1;
				@(negedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_taken);
		end
	end

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_pose(input pose_t p);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x    <= p.px;
		pos_y    <= p.py;
		pos_z    <= p.pz;
		scale_x  <= p.sx;
		scale_y  <= p.sy;
		scale_z  <= p.sz;
		quat_w   <= p.qw;
		quat_x   <= p.qx;
		quat_y   <= p.qy;
		quat_z   <= p.qz;
		do @(negedge clk); while (!in_taken);
	endtask

	// Let every outstanding item come out, then a few more cycles.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_e idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// Write all six registers, optionally followed by writes to the unused indexes.
	task automatic load_config(input logic [31:0] sx, sy, sz, ox, oy, oz, input bit spare);
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		write_reg(REG_OFF_X, ox);
		write_reg(REG_OFF_Y, oy);
		write_reg(REG_OFF_Z, oz);
		if (spare) begin
			write_reg(REG_SPARE_A, $urandom);
			write_reg(REG_SPARE_B, $urandom);
		end
		cfg_we <= 1'b0;
	endtask

	// Box size; the top bit of the write data is random since it is not stored.
	function automatic logic [31:0] rand_size();
		logic [30:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: v = 31'($urandom);
			default: v = 31'($urandom_range(0, 8 * UNIT));
		endcase
		return {1'($urandom_range(0, 1)), v};
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 8 * UNIT) - 4 * UNIT;
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return $urandom;
			default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [30:0] rand_scale();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
			1: return 31'($urandom);
			default: return 31'($urandom_range(0, 4 * UNIT));
		endcase
	endfunction

	// Mostly unit quaternions; some raw bit patterns and some edge components.
	function automatic pose_t rand_pose();
		pose_t p;
		real   a [4];
		real   n;
		int    q [4];
		int    edges [5];
		edges = '{Q_ONE, -Q_ONE, 0, -32768, 32767};
		p.px = rand_pos();
		p.py = rand_pos();
		p.pz = rand_pos();
		p.sx = rand_scale();
		p.sy = rand_scale();
		p.sz = rand_scale();
		case ($urandom_range(0, 9))
			0: begin
				for (int k = 0; k < 4; k++) q[k] = $urandom_range(0, 65535);
			end
			1: begin
				for (int k = 0; k < 4; k++) q[k] = edges[$urandom_range(0, 4)];
			end
			default: begin
				n = 0.0;
				for (int k = 0; k < 4; k++) begin
					a[k] = $itor($urandom_range(0, 65535)) - 32768.0;
					n += a[k] * a[k];
				end
				n = $sqrt(n);
				if (n < 1.0) begin
					q = '{Q_ONE, 0, 0, 0};
				end else begin
					for (int k = 0; k < 4; k++) q[k] = $rtoi(a[k] * Q_ONE / n);
				end
			end
		endcase
		p.qw = 16'(q[0]);
		p.qx = 16'(q[1]);
		p.qy = 16'(q[2]);
		p.qz = 16'(q[3]);
		return p;
	endfunction

	// Directed items: position and scale extremes, axis rotations, and quaternions
	// that are zero, not of unit length or outside the nominal range.
	function automatic pose_t directed_pose(input int n);
		pose_t p;
		p = '{px: 0, py: 0, pz: 0, sx: 31'(UNIT), sy: 31'(UNIT), sz: 31'(UNIT),
			qw: 16'(Q_ONE), qx: 0, qy: 0, qz: 0};
		case (n)
			1: begin
				p.px = 32'h7FFF_FFFF; p.py = 32'h7FFF_FFFF; p.pz = 32'h7FFF_FFFF;
			end
			2: begin
				p.px = 32'h8000_0000; p.py = 32'h8000_0000; p.pz = 32'h8000_0000;
			end
			3: begin
				p.sx = '1; p.sy = '1; p.sz = '1;
			end
			4: begin
				p.sx = '0; p.sy = '0; p.sz = '0;
			end
			5: begin
				p.qw = 16'sd11585; p.qz = 16'sd11585; p.sx = 31'(2 * UNIT);
			end
			6: begin
				p.qw = '0; p.qx = 16'(Q_ONE); p.py = -5 * UNIT;
			end
			7: begin
				p.qw = '0; p.qy = 16'(-Q_ONE); p.sz = 31'(3 * UNIT);
			end
			8: begin
				p.qw = 16'(Q_ONE); p.qx = 16'(Q_ONE); p.qy = 16'(Q_ONE); p.qz = 16'(Q_ONE);
			end
			9: begin
				p.qw = '0;
			end
			10: begin
				p.qw = 16'h8000; p.qx = 16'h7FFF; p.qy = 16'h8000; p.qz = 16'h7FFF;
				p.px = 32'h7FFF_FFFF; p.pz = 32'h8000_0000;
			end
			11: begin
				p.px = -1; p.py = 32'h5555_5555; p.pz = 32'hAAAA_AAAA;
				p.sx = 31'(UNIT + UNIT / 2); p.sy = 31'h2AAA_AAAA; p.sz = 31'h5555_5555;
				p.qw = 16'sd8192; p.qx = -16'sd8192; p.qy = 16'sd8192; p.qz = -16'sd8192;
			end
			default: ;
		endcase
		return p;
	endfunction

	// Main sequence: reset, directed items under two settings, then random phases.
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) send_pose(directed_pose(i));
		wait_drained();
		load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		for (int i = 0; i < NUM_DIRECTED; i++) send_pose(directed_pose(i));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			calm = ($urandom_range(0, 3) == 0);
			if (ph == 0) begin
				load_config(32'h0, 32'h0, 32'h0,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
			end else begin
				load_config(rand_size(), rand_size(), rand_size(),
					rand_offset(), rand_offset(), rand_offset(), $urandom_range(0, 1));
			end
			for (int i = 0; i < PHASE_ITEMS; i++) send_pose(rand_pose());
		end

		wait_drained();
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#400us;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/obb_pkg.sv
rtl/core/obb_rotmat.sv
rtl/core/oriented_box_to_aabb_core.sv
tb/obb_bounds_checker.sv
tb/tb_oriented_box_to_aabb_core.sv
